// ----- rtl/simon_pkg.sv -----
// Shared constants, types and the z-sequence table for the Simon cipher block.
`timescale 1ns / 1ps

package simon_pkg;

   // default cipher geometry: Simon64/128
   localparam int DEF_WORD_BITS      = 32;
   localparam int DEF_KEY_WORD_COUNT = 4;
   localparam int DEF_ROUND_COUNT    = 44;
   localparam int DEF_Z_SEQ_INDEX    = 3;

   // stream field widths
   localparam int HALF_BITS   = 32;
   localparam int ROUNDS_BITS = 6;
   localparam int REQ_BITS    = 72;   // left, right, round count, 2 pad bits
   localparam int RSP_BITS    = 64;

   // configuration port
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int KEY_REG_COUNT  = 4;
   localparam int KEY_SEL_BITS   = 2;

   // z sequences, first element in the msb
   localparam int SEQ_LEN   = 62;
   localparam int SEQ_COUNT = 5;
   localparam int Z_BITS    = 6;

   localparam logic [SEQ_LEN-1:0] Z_SEQ [SEQ_COUNT] = '{
      62'b1111101000100101011000011100110_1111101000100101011000011100110,
      62'b1000111011111001001100001011010_1000111011111001001100001011010,
      62'b1010111101_1100000011_0100100110_0010100001_0001111110_0101101100_11,
      62'b1101101110_1011000110_0101111000_0001001000_1010011100_1101000011_11,
      62'b1101000111_1001101011_0110001000_0001011100_0011001010_0100111011_11
   };

   typedef logic [KEY_REG_COUNT-1:0][CSR_DATA_BITS-1:0] key_bank_type;

   // controller to datapath commands
   typedef struct packed {
      logic                    exp_en;    // key schedule step, writes round key store
      logic                    key_load;  // take a raw key word instead of a derived one
      logic [KEY_SEL_BITS-1:0] key_sel;
      logic                    blk_load;  // capture an accepted item
      logic                    round_en;
      logic                    dec;
      logic                    out_load;
   } cmd_type;

   function automatic logic z_bit(input int seq, input logic [Z_BITS-1:0] pos);
      logic [SEQ_LEN-1:0] row;
      row = Z_SEQ[seq];
      return row[Z_BITS'(SEQ_LEN - 1) - pos];
   endfunction

endpackage

// ----- rtl/simon_ram.sv -----
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module simon_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 44
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/simon_csr.sv -----
// Key word registers behind the APB-style configuration port.
`timescale 1ns / 1ps

module simon_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [simon_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [simon_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [simon_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                csr_pready,
   output simon_pkg::key_bank_type             keys,
   output logic                                cfg_write
);
   import simon_pkg::*;

   key_bank_type             key_ff, key_in;
   logic [KEY_SEL_BITS-1:0]  reg_idx;

   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = key_ff[reg_idx];
   assign keys       = key_ff;

   always_comb begin
      key_in = key_ff;
      if (cfg_write) begin
         key_in[reg_idx] = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

endmodule

// ----- rtl/simon_ctrl.sv -----
// Controller: key schedule sweep, round sequencing and result handshake.
`timescale 1ns / 1ps

module simon_ctrl #(
   parameter int KEY_WORD_COUNT = simon_pkg::DEF_KEY_WORD_COUNT,
   parameter int ROUND_COUNT    = simon_pkg::DEF_ROUND_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cfg_write,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_op,
   input  logic [simon_pkg::ROUNDS_BITS-1:0] req_num_rounds,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output simon_pkg::cmd_type                cmd,
   output logic [$clog2(ROUND_COUNT)-1:0]    ram_wr_addr,
   output logic [$clog2(ROUND_COUNT)-1:0]    ram_rd_addr
);
   import simon_pkg::*;

   localparam int ADDR_BITS = $clog2(ROUND_COUNT);
   localparam int CNT_BITS  = $clog2(ROUND_COUNT + 1);

   localparam logic [1:0] S_EXPAND = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_ROUND  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_BITS-1:0] last_ff, last_in;
   logic                op_ff, op_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [CNT_BITS-1:0] cnt_inc;
   logic [CNT_BITS-1:0] n_sat;
   logic [CNT_BITS-1:0] rd_idx;
   logic                rd_op;

   assign cnt_inc = cnt_ff + CNT_BITS'(1);
   assign n_sat   = (7'(req_num_rounds) > 7'(ROUND_COUNT)) ? CNT_BITS'(ROUND_COUNT)
                                                           : CNT_BITS'(req_num_rounds);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rd_idx       = cnt_inc;
      rd_op        = op_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_EXPAND: begin
            cmd.exp_en   = 1'b1;
            cmd.key_load = (cnt_ff < CNT_BITS'(KEY_WORD_COUNT));
            cmd.key_sel  = cnt_ff[KEY_SEL_BITS-1:0];
            if (cnt_ff == CNT_BITS'(ROUND_COUNT - 1)) begin
               state_in = S_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            // prefetch the first round key of the incoming item
            rd_idx     = '0;
            rd_op      = req_op;
            if (req_tvalid) begin
               cmd.blk_load = 1'b1;
               op_in        = req_op;
               last_in      = n_sat;
               cnt_in       = '0;
               state_in     = (n_sat == '0) ? S_FINISH : S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            cnt_in       = cnt_inc;
            if (cnt_inc == last_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_EXPAND;
            cnt_in   = '0;
         end
      endcase

      cmd.dec = op_ff;

      // a new key restarts the schedule
      if (cfg_write) begin
         state_in = S_EXPAND;
         cnt_in   = '0;
      end
   end

   // decryption walks the round keys from the top down
   assign ram_rd_addr = rd_op ? ADDR_BITS'(CNT_BITS'(ROUND_COUNT - 1) - rd_idx)
                              : ADDR_BITS'(rd_idx);
   assign ram_wr_addr = ADDR_BITS'(cnt_ff);
   assign rsp_tvalid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_EXPAND;
         cnt_ff       <= '0;
         last_ff      <= '0;
         op_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/simon_dp.sv -----
// Datapath: key schedule window, round key store, round function and result register.
`timescale 1ns / 1ps

module simon_dp #(
   parameter int WORD_BITS        = simon_pkg::DEF_WORD_BITS,
   parameter int KEY_WORD_COUNT   = simon_pkg::DEF_KEY_WORD_COUNT,
   parameter int ROUND_COUNT      = simon_pkg::DEF_ROUND_COUNT,
   parameter int Z_SEQUENCE_INDEX = simon_pkg::DEF_Z_SEQ_INDEX
) (
   input  logic                            clock,
   input  simon_pkg::cmd_type              cmd,
   input  simon_pkg::key_bank_type         keys,
   input  logic [$clog2(ROUND_COUNT)-1:0]  ram_wr_addr,
   input  logic [$clog2(ROUND_COUNT)-1:0]  ram_rd_addr,
   input  logic [simon_pkg::HALF_BITS-1:0] left_in,
   input  logic [simon_pkg::HALF_BITS-1:0] right_in,
   output logic [simon_pkg::HALF_BITS-1:0] left_out,
   output logic [simon_pkg::HALF_BITS-1:0] right_out
);
   import simon_pkg::*;

   localparam int Z_ROW = Z_SEQUENCE_INDEX % SEQ_COUNT;
   localparam logic [WORD_BITS-1:0] SCHED_C = ~WORD_BITS'(3);

   function automatic logic [WORD_BITS-1:0] rol(input logic [WORD_BITS-1:0] x, input int d);
      return (x << d) | (x >> (WORD_BITS - d));
   endfunction

   function automatic logic [WORD_BITS-1:0] ror(input logic [WORD_BITS-1:0] x, input int d);
      return (x >> d) | (x << (WORD_BITS - d));
   endfunction

   function automatic logic [WORD_BITS-1:0] round_f(input logic [WORD_BITS-1:0] x);
      return (rol(x, 1) & rol(x, 8)) ^ rol(x, 2);
   endfunction

   // win_ff[0] is the newest round key, win_ff[KEY_WORD_COUNT-1] the oldest
   logic [KEY_WORD_COUNT-1:0][WORD_BITS-1:0] win_ff, win_in;
   logic [Z_BITS-1:0]                        zcnt_ff, zcnt_in;
   logic [WORD_BITS-1:0]                     l_ff, l_in;
   logic [WORD_BITS-1:0]                     r_ff, r_in;
   logic [HALF_BITS-1:0]                     lo_ff, lo_in;
   logic [HALF_BITS-1:0]                     ro_ff, ro_in;

   logic [WORD_BITS-1:0] sched_t;
   logic [WORD_BITS-1:0] key_new;
   logic [WORD_BITS-1:0] round_key;

   simon_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ROUND_COUNT)
   ) u_key_ram (
      .clock (clock),
      .we    (cmd.exp_en),
      .waddr (ram_wr_addr),
      .wdata (key_new),
      .raddr (ram_rd_addr),
      .rdata (round_key)
   );

   always_comb begin
      sched_t = ror(win_ff[0], 3);
      // with four key words this is key i-3
      if (KEY_WORD_COUNT == 4) begin
         sched_t = sched_t ^ win_ff[KEY_WORD_COUNT-2];
      end
      sched_t = sched_t ^ ror(sched_t, 1);
      key_new = win_ff[KEY_WORD_COUNT-1] ^ WORD_BITS'(z_bit(Z_ROW, zcnt_ff)) ^ sched_t ^ SCHED_C;
      if (cmd.key_load) begin
         key_new = WORD_BITS'(keys[cmd.key_sel]);
      end
   end

   always_comb begin
      win_in  = win_ff;
      zcnt_in = zcnt_ff;
      if (cmd.exp_en) begin
         if (KEY_WORD_COUNT > 1) begin
            win_in = {win_ff[KEY_WORD_COUNT-2:0], key_new};
         end
         if (cmd.key_load) begin
            zcnt_in = '0;
         end else if (zcnt_ff == Z_BITS'(SEQ_LEN - 1)) begin
            zcnt_in = '0;
         end else begin
            zcnt_in = zcnt_ff + Z_BITS'(1);
         end
      end
   end

   always_comb begin
      l_in  = l_ff;
      r_in  = r_ff;
      lo_in = lo_ff;
      ro_in = ro_ff;
      if (cmd.blk_load) begin
         l_in = WORD_BITS'(left_in);
         r_in = WORD_BITS'(right_in);
      end else if (cmd.round_en) begin
         if (cmd.dec) begin
            r_in = l_ff ^ round_f(r_ff) ^ round_key;
            l_in = r_ff;
         end else begin
            l_in = r_ff ^ round_f(l_ff) ^ round_key;
            r_in = l_ff;
         end
      end
      if (cmd.out_load) begin
         lo_in = HALF_BITS'(l_ff);
         ro_in = HALF_BITS'(r_ff);
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      zcnt_ff <= zcnt_in;
      l_ff    <= l_in;
      r_ff    <= r_in;
      lo_ff   <= lo_in;
      ro_ff   <= ro_in;
   end

   assign left_out  = lo_ff;
   assign right_out = ro_ff;

endmodule

// ----- rtl/simon_block_cipher.sv -----
// An item is accepted only in the idle state, so the block takes no new item until the last
// result has been loaded; rounds are capped at ROUND_COUNT. One round per cycle, each reading
//   one round key from the key store (one write and one read port).
// Reset and every key write start a key schedule sweep over all ROUND_COUNT round keys, one round key
//   per cycle; req_tready stays low until the store is rebuilt. Key registers reset to zero.
`timescale 1ns / 1ps

module simon_block_cipher #(
   parameter int WORD_BITS        = simon_pkg::DEF_WORD_BITS,
   parameter int KEY_WORD_COUNT   = simon_pkg::DEF_KEY_WORD_COUNT,
   parameter int ROUND_COUNT      = simon_pkg::DEF_ROUND_COUNT,
   parameter int Z_SEQUENCE_INDEX = simon_pkg::DEF_Z_SEQ_INDEX
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] left_in, [63:32] right_in, [69:64] num_rounds, [71:70] zero
   input  logic [simon_pkg::REQ_BITS-1:0]      req_tdata,
   // [0] op (0 encrypt, 1 decrypt)
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] left_out, [63:32] right_out
   output logic [simon_pkg::RSP_BITS-1:0]      rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [simon_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [simon_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [simon_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                csr_pready
);
   import simon_pkg::*;

   localparam int ADDR_BITS = $clog2(ROUND_COUNT);

   key_bank_type          keys;
   logic                  cfg_write;
   cmd_type               cmd;
   logic [ADDR_BITS-1:0]  ram_wr_addr;
   logic [ADDR_BITS-1:0]  ram_rd_addr;
   logic [HALF_BITS-1:0]  left_out;
   logic [HALF_BITS-1:0]  right_out;

   simon_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .keys        (keys),
      .cfg_write   (cfg_write)
   );

   simon_ctrl #(
      .KEY_WORD_COUNT (KEY_WORD_COUNT),
      .ROUND_COUNT    (ROUND_COUNT)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg_write      (cfg_write),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_op         (req_tuser),
      .req_num_rounds (req_tdata[2*HALF_BITS +: ROUNDS_BITS]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .cmd            (cmd),
      .ram_wr_addr    (ram_wr_addr),
      .ram_rd_addr    (ram_rd_addr)
   );

   simon_dp #(
      .WORD_BITS        (WORD_BITS),
      .KEY_WORD_COUNT   (KEY_WORD_COUNT),
      .ROUND_COUNT      (ROUND_COUNT),
      .Z_SEQUENCE_INDEX (Z_SEQUENCE_INDEX)
   ) u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .keys        (keys),
      .ram_wr_addr (ram_wr_addr),
      .ram_rd_addr (ram_rd_addr),
      .left_in     (req_tdata[HALF_BITS-1:0]),
      .right_in    (req_tdata[HALF_BITS +: HALF_BITS]),
      .left_out    (left_out),
      .right_out   (right_out)
   );

   assign rsp_tdata = {right_out, left_out};

endmodule

// ----- tb/tb_simon_block_cipher.sv -----
// Self-checking testbench for the Simon64/128 block cipher stream core.
`timescale 1ns / 1ps

module tb_simon_block_cipher;

   localparam int NR          = simon_pkg::DEF_ROUND_COUNT;
   localparam int HB          = simon_pkg::HALF_BITS;
   localparam int RB          = simon_pkg::ROUNDS_BITS;
   localparam int GAP_PCT     = 18;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 3000;
   localparam int TAIL_CYCLES = NR + 16;
   localparam int MAX_REPORTS = 40;

   localparam logic [HB-1:0] SCHED_CONST = 32'hFFFF_FFFC;   // 2^n - 4
   // z3 sequence, element 0 in the msb
   localparam logic [61:0] Z3 =
      62'b1101101110_1011000110_0101111000_0001001000_1010011100_1101000011_11;

   typedef enum bit {OP_ENCRYPT = 1'b0, OP_DECRYPT = 1'b1} op_type;
   typedef enum int {KEY_WORD_0 = 0, KEY_WORD_1 = 1, KEY_WORD_2 = 2, KEY_WORD_3 = 3} key_reg_type;

   typedef struct {
      op_type        op;
      logic [HB-1:0] left;
      logic [HB-1:0] right;
      logic [RB-1:0] rounds;
   } block_type;

   typedef struct packed {
      logic [HB-1:0] left;
      logic [HB-1:0] right;
   } half_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [simon_pkg::REQ_BITS-1:0]      req_tdata = '0;
   logic                                req_tuser = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [simon_pkg::RSP_BITS-1:0]      rsp_tdata;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [simon_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [simon_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [simon_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                                csr_pready;

   simon_block_cipher DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [HB-1:0] key_shadow [4];
   logic [HB-1:0] round_keys [NR];

   block_type     pending_blocks [$];
   half_pair_type expected_halves [$];

   bit no_gaps       = 1'b0;
   bit rx_hold_armed = 1'b0;
   bit rx_hold_used  = 1'b0;
   int rx_hold_left  = 0;

   int mismatches    = 0;
   int blocks_in     = 0;
   int results_out   = 0;
   int decrypt_count = 0;
   int capped_count  = 0;
   int key_settings  = 1;
   int stall_cycles  = 0;

   function automatic logic [HB-1:0] rotl(logic [HB-1:0] x, int d);
      return (x << d) | (x >> (HB - d));
   endfunction

   function automatic logic [HB-1:0] rotr(logic [HB-1:0] x, int d);
      return (x >> d) | (x << (HB - d));
   endfunction

   function automatic logic [HB-1:0] feistel_mix(logic [HB-1:0] x);
      return (rotl(x, 1) & rotl(x, 8)) ^ rotl(x, 2);
   endfunction

   function automatic void expand_round_keys();
      logic [HB-1:0] t;
      for (int i = 0; i < 4; i++)
         round_keys[i] = key_shadow[i];
      for (int i = 4; i < NR; i++) begin
         t = rotr(round_keys[i-1], 3) ^ round_keys[i-3];
         t = t ^ rotr(t, 1);
         round_keys[i] = round_keys[i-4] ^ HB'(Z3[61 - (i - 4)]) ^ t ^ SCHED_CONST;
      end
   endfunction

   function automatic half_pair_type encipher_block(block_type blk);
      int            n;
      logic [HB-1:0] l;
      logic [HB-1:0] r;
      logic [HB-1:0] t;
      half_pair_type res;
      n = (blk.rounds > NR) ? NR : int'(blk.rounds);
      l = blk.left;
      r = blk.right;
      for (int i = 0; i < n; i++) begin
         if (blk.op == OP_ENCRYPT) begin
            t = l;
            l = r ^ feistel_mix(l) ^ round_keys[i];
            r = t;
         end else begin
            t = r;
            r = l ^ feistel_mix(r) ^ round_keys[NR - 1 - i];
            l = t;
         end
      end
      res.left  = l;
      res.right = r;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [HB-1:0] got, logic [HB-1:0] want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      block_type blk;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_blocks.size() > 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
            blk = pending_blocks.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {2'b00, blk.rounds, blk.right, blk.left};
            req_tuser  <= blk.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver, with one long hold-off when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_hold_armed && !rx_hold_used) begin
         rx_hold_used <= 1'b1;
         rx_hold_left <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left <= rx_hold_left - 1;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
      end
   end

   // monitor: predict on request accept, check on result accept
   always @(posedge clock) begin : watch_stream
      block_type     blk;
      half_pair_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            blk.op     = op_type'(req_tuser);
            blk.left   = req_tdata[HB-1:0];
            blk.right  = req_tdata[2*HB-1:HB];
            blk.rounds = req_tdata[2*HB+RB-1:2*HB];
            expected_halves.push_back(encipher_block(blk));
            blocks_in++;
            if (blk.op == OP_DECRYPT)
               decrypt_count++;
            if (blk.rounds > NR)
               capped_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_out++;
            if (expected_halves.size() == 0) begin
               report_mismatch("result with no block pending", rsp_tdata[HB-1:0], '0);
            end else begin
               want = expected_halves.pop_front();
               if (rsp_tdata[HB-1:0] !== want.left)
                  report_mismatch("left_out", rsp_tdata[HB-1:0], want.left);
               if (rsp_tdata[2*HB-1:HB] !== want.right)
                  report_mismatch("right_out", rsp_tdata[2*HB-1:HB], want.right);
            end
         end
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic push_block(op_type op, logic [HB-1:0] l, logic [HB-1:0] r,
                             logic [RB-1:0] n);
      block_type blk;
      blk.op     = op;
      blk.left   = l;
      blk.right  = r;
      blk.rounds = n;
      pending_blocks.push_back(blk);
   endtask

   // register write; the block rebuilds its round keys afterwards
   task automatic write_key(key_reg_type idx, logic [HB-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= simon_pkg::CSR_ADDR_BITS'(4 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      key_shadow[idx] = value;
      expand_round_keys();
      repeat (NR + 4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_key(logic [HB-1:0] k0, logic [HB-1:0] k1,
                           logic [HB-1:0] k2, logic [HB-1:0] k3);
      write_key(KEY_WORD_0, k0);
      write_key(KEY_WORD_1, k1);
      write_key(KEY_WORD_2, k2);
      write_key(KEY_WORD_3, k3);
      key_settings++;
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_blocks.size() != 0 || req_tvalid || expected_halves.size() != 0);
   endtask

   task automatic run_random(int count);
      block_type blk;
      int        pick;
      for (int i = 0; i < count; i++) begin
         blk.op    = op_type'($urandom_range(1));
         blk.left  = $urandom;
         blk.right = $urandom;
         pick = $urandom_range(19);
         if (pick == 0)
            blk.left = '0;
         else if (pick == 1)
            blk.right = '1;
         pick = $urandom_range(9);
         if (pick < 4)
            blk.rounds = RB'(NR);
         else if (pick < 7)
            blk.rounds = RB'($urandom_range(63));
         else
            blk.rounds = RB'($urandom_range(NR));
         pending_blocks.push_back(blk);
      end
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < 4; i++)
         key_shadow[i] = '0;
      expand_round_keys();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // all-zero key from reset: extremes, pass-through and round cap
      push_block(OP_ENCRYPT, '0, '0, RB'(NR));
      push_block(OP_DECRYPT, '0, '0, RB'(NR));
      push_block(OP_ENCRYPT, '1, '1, '0);
      push_block(OP_DECRYPT, '1, '0, RB'(63));
      wait_drained();

      // published Simon64/128 vector, reduced-round and capped-round cases
      load_key(32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110, 32'h1b1a_1918);
      push_block(OP_ENCRYPT, 32'h656b_696c, 32'h2064_6e75, RB'(NR));
      push_block(OP_DECRYPT, 32'h44c8_fc20, 32'hb9df_a07a, RB'(NR));
      push_block(OP_ENCRYPT, $urandom, $urandom, RB'(1));
      push_block(OP_ENCRYPT, $urandom, $urandom, RB'(NR - 1));
      push_block(OP_ENCRYPT, $urandom, $urandom, RB'(NR + 1));
      push_block(OP_ENCRYPT, $urandom, $urandom, RB'(63));
      push_block(OP_DECRYPT, $urandom, $urandom, RB'(1));
      push_block(OP_DECRYPT, $urandom, $urandom, RB'(NR - 1));
      push_block(OP_DECRYPT, $urandom, $urandom, RB'(NR + 1));
      push_block(OP_DECRYPT, $urandom, $urandom, '0);
      push_block(OP_ENCRYPT, '1, '0, RB'(NR));
      push_block(OP_ENCRYPT, '0, '1, RB'(NR));
      push_block(OP_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555, RB'(NR));
      push_block(OP_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa, RB'(NR));
      wait_drained();

      // gap-free stretch; receiver stalls long at the start so the core backs up
      no_gaps       = 1'b1;
      rx_hold_armed = 1'b1;
      run_random(400);
      no_gaps = 1'b0;

      load_key('1, '1, '1, '1);
      run_random(300);

      // single register change
      write_key(KEY_WORD_2, $urandom);
      key_settings++;
      run_random(250);

      repeat (3) begin
         load_key($urandom, $urandom, $urandom, $urandom);
         run_random(280);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (expected_halves.size() != 0)
         report_mismatch("results never returned", expected_halves.size(), '0);

      $display("Run covered %0d blocks (%0d decrypt, %0d with rounds above %0d) under %0d keys",
               blocks_in, decrypt_count, capped_count, NR, key_settings);
      $display("%0d results compared, %0d mismatches", results_out, mismatches);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
